// ===== sv/ambient_light_backlight_dimmer_defines.svh =====
// Assertion helpers shared by the dimmer RTL.
// Each helper is compiled out for synthesis.
`ifndef AMBIENT_LIGHT_BACKLIGHT_DIMMER_DEFINES_SVH
`define AMBIENT_LIGHT_BACKLIGHT_DIMMER_DEFINES_SVH

`ifndef SYNTHESIS

// Plain invariant, checked at every edge out of reset
`define ALBD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("albd: invariant check failed");

// Same-cycle implication
`define ALBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("albd: implication check failed");

// Next-cycle implication
`define ALBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("albd: next-cycle check failed");

`else

`define ALBD_ASSERT(lbl, clk, rst_n, prop)
`define ALBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ALBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/albd_pkg.sv =====
`timescale 1ns / 1ps

package albd_pkg;

  // Default build parameters
  localparam int TIME_BITS_DEF = 32;
  localparam int ADC_BITS_DEF  = 12;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int IVL_W    = 16;
  localparam int RUN_W    = 8;
  localparam int FS_W     = 13;
  localparam int DUTY_W   = 8;
  localparam int PCT_W    = 7;
  localparam int MV_W     = 13;
  localparam int PROD_W   = SAMPLE_W + FS_W;

  // Run counters saturate here
  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  // Configuration port
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 5;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_READ_IVL   = 3'd0;
  localparam logic [2:0] REG_CHANGE_IVL = 3'd1;
  localparam logic [2:0] REG_RUN_LEN    = 3'd2;
  localparam logic [2:0] REG_BRIGHT_THR = 3'd3;
  localparam logic [2:0] REG_FULL_SCALE = 3'd4;
  localparam logic [2:0] REG_BRIGHT_LVL = 3'd5;
  localparam logic [2:0] REG_DIM_LVL    = 3'd6;

  // Register reset values
  localparam logic [IVL_W-1:0]    READ_IVL_RST   = 16'd100;
  localparam logic [IVL_W-1:0]    CHANGE_IVL_RST = 16'd1000;
  localparam logic [RUN_W-1:0]    RUN_LEN_RST    = 8'd5;
  localparam logic [SAMPLE_W-1:0] BRIGHT_THR_RST = 12'd1985;
  localparam logic [FS_W-1:0]     FULL_SCALE_RST = 13'd3300;
  localparam logic [DUTY_W-1:0]   BRIGHT_LVL_RST = 8'd255;
  localparam logic [DUTY_W-1:0]   DIM_LVL_RST    = 8'd76;

  // Backlight duty after reset: full brightness
  localparam logic [DUTY_W-1:0]   DUTY_RST       = 8'd255;

  typedef struct packed {
    logic [IVL_W-1:0]    read_ivl;
    logic [IVL_W-1:0]    change_ivl;
    logic [RUN_W-1:0]    run_len;
    logic [SAMPLE_W-1:0] bright_thr;
    logic [FS_W-1:0]     full_scale;
    logic [DUTY_W-1:0]   bright_lvl;
    logic [DUTY_W-1:0]   dim_lvl;
  } albd_cfg_t;

  // Outcome of one sample through the control step
  typedef struct packed {
    logic              accept;
    logic              changed;
    logic [DUTY_W-1:0] duty;
  } albd_step_t;

endpackage

// ===== sv/albd_if.sv =====
`timescale 1ns / 1ps

// Sample channel: timestamp and raw ADC reading
interface albd_in_if import albd_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] time_ms;
  logic [SAMPLE_W-1:0]  light_sample;

  modport source (output valid, time_ms, light_sample, input ready);
  modport sink   (input valid, time_ms, light_sample, output ready);
endinterface

// Result channel: backlight duty and reporting values
interface albd_out_if import albd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_level;
  logic [PCT_W-1:0]  duty_percent;
  logic [MV_W-1:0]   light_mv;
  logic              level_changed;

  modport source (output valid, duty_level, duty_percent, light_mv, level_changed,
                  input ready);
  modport sink   (input valid, duty_level, duty_percent, light_mv, level_changed,
                  output ready);
endinterface

// ===== sv/albd_ctrl.sv =====
`timescale 1ns / 1ps

`include "ambient_light_backlight_dimmer_defines.svh"

module albd_ctrl import albd_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  albd_cfg_t            cfg,
  input  logic                 item_v,
  input  logic                 adv,
  input  logic [TIME_BITS-1:0] time_ms,
  input  logic [SAMPLE_W-1:0]  sample,
  output albd_step_t           step
);

  logic [TIME_BITS-1:0] last_smp_r;
  logic [TIME_BITS-1:0] last_chg_r;
  logic [RUN_W-1:0]     bright_run_r;
  logic [RUN_W-1:0]     dim_run_r;
  logic [DUTY_W-1:0]    duty_r;

  logic [TIME_BITS-1:0] since_smp;
  logic [TIME_BITS-1:0] since_chg;
  logic                 accept;
  logic                 rate_ok;
  logic                 bright;
  logic [RUN_W-1:0]     bright_run_nxt;
  logic [RUN_W-1:0]     dim_run_nxt;
  logic [DUTY_W-1:0]    duty_nxt;
  logic                 chg;
  logic                 upd;

  // Wrapping elapsed times against both timestamps
  assign since_smp = time_ms - last_smp_r;
  assign since_chg = time_ms - last_chg_r;
  assign accept    = since_smp >= TIME_BITS'(cfg.read_ivl);
  assign rate_ok   = since_chg >= TIME_BITS'(cfg.change_ivl);
  assign bright    = sample > cfg.bright_thr;
  assign upd       = item_v && adv && accept;

  // Run counting and level decision; bright is tested first
  always_comb begin
    bright_run_nxt = '0;
    dim_run_nxt    = '0;
    duty_nxt       = duty_r;
    chg            = 1'b0;
    if (bright) begin
      bright_run_nxt = (bright_run_r == RUN_MAX) ? RUN_MAX : bright_run_r + 8'd1;
    end else begin
      dim_run_nxt = (dim_run_r == RUN_MAX) ? RUN_MAX : dim_run_r + 8'd1;
    end
    if (bright_run_nxt >= cfg.run_len) begin
      if ((duty_r != cfg.bright_lvl) && rate_ok) begin
        duty_nxt       = cfg.bright_lvl;
        bright_run_nxt = '0;
        chg            = 1'b1;
      end
    end else if (dim_run_nxt >= cfg.run_len) begin
      if ((duty_r != cfg.dim_lvl) && rate_ok) begin
        duty_nxt    = cfg.dim_lvl;
        dim_run_nxt = '0;
        chg         = 1'b1;
      end
    end
  end

  // State commits when the sample is taken into the next stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_smp_r   <= '0;
      last_chg_r   <= '0;
      bright_run_r <= '0;
      dim_run_r    <= '0;
      duty_r       <= DUTY_RST;
    end else if (upd) begin
      last_smp_r   <= time_ms;
      bright_run_r <= bright_run_nxt;
      dim_run_r    <= dim_run_nxt;
      duty_r       <= duty_nxt;
      if (chg) begin
        last_chg_r <= time_ms;
      end
    end
  end

  assign step.accept  = accept;
  assign step.changed = chg;
  assign step.duty    = duty_nxt;

  // At most one run is ever counting
  `ALBD_ASSERT(a_runs_excl, clk, rst_n, (bright_run_r == '0) || (dim_run_r == '0))
  // Duty moves only through a level change
  `ALBD_ASSERT_IMP(a_duty_on_change, clk, rst_n, $past(rst_n) && !$stable(duty_r),
                   $past(upd && chg))
  // Rate-limit timestamp moves only through a level change
  `ALBD_ASSERT_IMP(a_chg_time_on_change, clk, rst_n,
                   $past(rst_n) && !$stable(last_chg_r), $past(upd && chg))
  // A sample inside the read interval leaves the state alone
  `ALBD_ASSERT_NXT(a_reject_holds, clk, rst_n, item_v && adv && !accept,
                   $stable(last_smp_r) && $stable(bright_run_r) && $stable(dim_run_r))

endmodule

// ===== sv/albd_fmt.sv =====
`timescale 1ns / 1ps

module albd_fmt import albd_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic [DUTY_W-1:0] duty,
  input  logic [PROD_W-1:0] prod,
  output logic [PCT_W-1:0]  percent,
  output logic [MV_W-1:0]   mv
);

  // Fold steps for dividing a PROD_W value by 2^n-1, n >= 8
  localparam int FOLD_STEPS = 4;

  // Floor division by 2^n-1: add the high digit back into the low one,
  // then one final correction
  function automatic logic [PROD_W-1:0] div_mersenne(input logic [PROD_W-1:0] p,
                                                     input int unsigned n);
    logic [PROD_W-1:0] d;
    logic [PROD_W-1:0] q;
    logic [PROD_W-1:0] r;
    int                k;
    d = (PROD_W'(1) << n) - PROD_W'(1);
    q = '0;
    r = p;
    for (k = 0; k < FOLD_STEPS; k++) begin
      q = q + (r >> n);
      r = (r & d) + (r >> n);
    end
    if (r >= d) begin
      q = q + PROD_W'(1);
    end
    return q;
  endfunction

  logic [PROD_W-1:0] pct_x;
  logic [PROD_W-1:0] pct_q;
  logic [PROD_W-1:0] mv_q;

  // duty * 100 / 255
  assign pct_x   = PROD_W'(duty) * PROD_W'(100);
  assign pct_q   = div_mersenne(pct_x, DUTY_W);
  assign percent = pct_q[PCT_W-1:0];

  // sample * full scale / (2^ADC_BITS - 1)
  assign mv_q = div_mersenne(prod, ADC_BITS);
  assign mv   = mv_q[MV_W-1:0];

endmodule

// ===== sv/ambient_light_backlight_dimmer.sv =====
`timescale 1ns / 1ps

// Ambient-light backlight dimmer. Takes one sample beat per clock, back to
// back unless the result side stalls, and presents a registered result
// beat for each sample that falls outside the read interval; samples
// inside it produce no beat. The state update in albd_ctrl (elapsed-time
// checks, run counters, level choice) is the feedback loop that fixes the
// rate at one item per cycle; the millivolt product is registered and the
// two constant divisions by 2^n-1 run in the stage before the output
// register. Configuration registers sit on an APB-style port at byte
// address 4*index and are only to be written while no sample is in flight.
`include "ambient_light_backlight_dimmer_defines.svh"

module ambient_light_backlight_dimmer import albd_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int ADC_BITS  = ADC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  albd_in_if.sink           in_ch,
  albd_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam logic [SAMPLE_W-1:0] SMP_MASK =
    (ADC_BITS >= SAMPLE_W) ? '1 : SAMPLE_W'((32'd1 << ADC_BITS) - 32'd1);

  albd_cfg_t cfg_r;
  logic      cfg_wr;

  // Configuration writes
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_ivl   <= READ_IVL_RST;
      cfg_r.change_ivl <= CHANGE_IVL_RST;
      cfg_r.run_len    <= RUN_LEN_RST;
      cfg_r.bright_thr <= BRIGHT_THR_RST;
      cfg_r.full_scale <= FULL_SCALE_RST;
      cfg_r.bright_lvl <= BRIGHT_LVL_RST;
      cfg_r.dim_lvl    <= DIM_LVL_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_READ_IVL:   cfg_r.read_ivl   <= cfg_pwdata[IVL_W-1:0];
        REG_CHANGE_IVL: cfg_r.change_ivl <= cfg_pwdata[IVL_W-1:0];
        REG_RUN_LEN:    cfg_r.run_len    <= cfg_pwdata[RUN_W-1:0];
        REG_BRIGHT_THR: cfg_r.bright_thr <= cfg_pwdata[SAMPLE_W-1:0];
        REG_FULL_SCALE: cfg_r.full_scale <= cfg_pwdata[FS_W-1:0];
        REG_BRIGHT_LVL: cfg_r.bright_lvl <= cfg_pwdata[DUTY_W-1:0];
        REG_DIM_LVL:    cfg_r.dim_lvl    <= cfg_pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_paddr[4:2])
      REG_READ_IVL:   cfg_prdata = CFG_DW'(cfg_r.read_ivl);
      REG_CHANGE_IVL: cfg_prdata = CFG_DW'(cfg_r.change_ivl);
      REG_RUN_LEN:    cfg_prdata = CFG_DW'(cfg_r.run_len);
      REG_BRIGHT_THR: cfg_prdata = CFG_DW'(cfg_r.bright_thr);
      REG_FULL_SCALE: cfg_prdata = CFG_DW'(cfg_r.full_scale);
      REG_BRIGHT_LVL: cfg_prdata = CFG_DW'(cfg_r.bright_lvl);
      REG_DIM_LVL:    cfg_prdata = CFG_DW'(cfg_r.dim_lvl);
      default:        cfg_prdata = '0;
    endcase
  end

  // Pipeline occupancy and stage advance
  logic s1_v_r;
  logic s2_v_r;
  logic out_v_r;
  logic s3_free;
  logic s2_free;
  logic in_go;

  assign s3_free     = !out_v_r || out_ch.ready;
  assign s2_free     = !s2_v_r || s3_free;
  assign in_ch.ready = !s1_v_r || s2_free;
  assign in_go       = in_ch.valid && in_ch.ready;

  // Stage 1: input register
  logic [TIME_BITS-1:0] s1_time_r;
  logic [SAMPLE_W-1:0]  s1_smp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_go) begin
      s1_v_r <= 1'b1;
    end else if (s2_free) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_time_r <= in_ch.time_ms;
      s1_smp_r  <= in_ch.light_sample & SMP_MASK;
    end
  end

  // Control step on the stage-1 sample
  albd_step_t step;

  albd_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .item_v  (s1_v_r),
    .adv     (s2_free),
    .time_ms (s1_time_r),
    .sample  (s1_smp_r),
    .step    (step)
  );

  // Stage 2: decision and millivolt product
  logic [DUTY_W-1:0] s2_duty_r;
  logic              s2_chg_r;
  logic [PROD_W-1:0] s2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r && step.accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_duty_r <= step.duty;
      s2_chg_r  <= step.changed;
      s2_prod_r <= PROD_W'(s1_smp_r) * PROD_W'(cfg_r.full_scale);
    end
  end

  // Percent and millivolt scaling
  logic [PCT_W-1:0] pct;
  logic [MV_W-1:0]  mv;

  albd_fmt #(
    .ADC_BITS (ADC_BITS)
  ) u_fmt (
    .duty    (s2_duty_r),
    .prod    (s2_prod_r),
    .percent (pct),
    .mv      (mv)
  );

  // Stage 3: output register
  logic [DUTY_W-1:0] out_duty_r;
  logic [PCT_W-1:0]  out_pct_r;
  logic [MV_W-1:0]   out_mv_r;
  logic              out_chg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s3_free) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free) begin
      out_duty_r <= s2_duty_r;
      out_pct_r  <= pct;
      out_mv_r   <= mv;
      out_chg_r  <= s2_chg_r;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.duty_level    = out_duty_r;
  assign out_ch.duty_percent  = out_pct_r;
  assign out_ch.light_mv      = out_mv_r;
  assign out_ch.level_changed = out_chg_r;

  // An empty output stage means the whole pipe can move
  `ALBD_ASSERT_IMP(a_ready_when_drained, clk, rst_n, !out_v_r, in_ch.ready)

endmodule

// ===== dv/tb_ambient_light_backlight_dimmer.sv =====
`timescale 1ns / 1ps

module tb_ambient_light_backlight_dimmer;
  import albd_pkg::*;

  localparam int unsigned ADC_FULL       = (1 << ADC_BITS_DEF) - 1;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          RX_HOLD_CYCLES = 200;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_EVERY4} rx_mode_t;
  typedef enum int {SEQ_BRIGHT, SEQ_DIM, SEQ_NOISE} light_seq_t;

  // One expected result beat
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [PCT_W-1:0]  pct;
    logic [MV_W-1:0]   mv;
    logic              changed;
  } backlight_result_t;

  logic clk;
  logic rst_n;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  albd_in_if #(.TIME_BITS(TIME_BITS_DEF)) in_if ();
  albd_out_if out_if ();

  ambient_light_backlight_dimmer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Dimmer shadow: register copy and control state
  albd_cfg_t         dim_cfg;
  logic [31:0]       last_sample_ms;
  logic [31:0]       last_change_ms;
  logic [RUN_W-1:0]  bright_cnt;
  logic [RUN_W-1:0]  dim_cnt;
  logic [DUTY_W-1:0] duty_now;

  backlight_result_t pending_results[$];
  int                mismatches = 0;

  // Stimulus bookkeeping
  logic [31:0] clock_ms    = '0;
  int          burst_left  = 0;
  bit          tx_gapless  = 1'b0;
  bit          rx_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Backlight control step for one sample beat; returns 1 when a result is due
  function automatic bit predict_backlight(input logic [31:0] stamp,
                                           input logic [SAMPLE_W-1:0] sample,
                                           output backlight_result_t res);
    logic [31:0]  since_sample;
    logic [31:0]  since_change;
    bit           rate_ok;
    bit           switched;
    int unsigned  mv_full;
    int unsigned  pct_full;
    since_sample = stamp - last_sample_ms;
    res = '0;
    if (since_sample < {16'd0, dim_cfg.read_ivl}) return 1'b0;
    last_sample_ms = stamp;
    switched = 1'b0;

    // run counters, saturating
    if (sample > dim_cfg.bright_thr) begin
      if (bright_cnt != RUN_MAX) bright_cnt = bright_cnt + 1'b1;
      dim_cnt = '0;
    end else begin
      if (dim_cnt != RUN_MAX) dim_cnt = dim_cnt + 1'b1;
      bright_cnt = '0;
    end

    // bright side wins when both qualify
    since_change = stamp - last_change_ms;
    rate_ok = since_change >= {16'd0, dim_cfg.change_ivl};
    if (bright_cnt >= dim_cfg.run_len) begin
      if (duty_now != dim_cfg.bright_lvl && rate_ok) begin
        duty_now = dim_cfg.bright_lvl;
        last_change_ms = stamp;
        bright_cnt = '0;
        switched = 1'b1;
      end
    end else if (dim_cnt >= dim_cfg.run_len) begin
      if (duty_now != dim_cfg.dim_lvl && rate_ok) begin
        duty_now = dim_cfg.dim_lvl;
        last_change_ms = stamp;
        dim_cnt = '0;
        switched = 1'b1;
      end
    end

    mv_full  = (int'(sample) * int'(dim_cfg.full_scale)) / ADC_FULL;
    pct_full = (int'(duty_now) * 100) / 255;
    res.duty    = duty_now;
    res.pct     = pct_full[PCT_W-1:0];
    res.mv      = mv_full[MV_W-1:0];
    res.changed = switched;
    return 1'b1;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Scoreboard: retire result beats, then predict the accepted sample beat
  always @(posedge clk) begin : scoreboard
    backlight_result_t r;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: expected none, actual duty %0d mv %0d",
                   $time, out_if.duty_level, out_if.light_mv);
        end else begin
          r = pending_results.pop_front();
          check_field("duty_level", 32'(r.duty), 32'(out_if.duty_level));
          check_field("duty_percent", 32'(r.pct), 32'(out_if.duty_percent));
          check_field("light_mv", 32'(r.mv), 32'(out_if.light_mv));
          check_field("level_changed", 32'(r.changed), 32'(out_if.level_changed));
        end
      end
      if (in_if.valid && in_if.ready) begin
        if (predict_backlight(in_if.time_ms, in_if.light_sample, r))
          pending_results.push_back(r);
      end
    end
  end

  // Result-side ready: random segments of patterns plus the long hold-off
  initial begin : rx_pattern
    rx_mode_t mode;
    int       seg_left;
    int       hold_left;
    out_if.ready = 1'b0;
    mode = RX_ALWAYS;
    seg_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 150);
        end
        seg_left--;
        case (mode)
          RX_ALWAYS: out_if.ready <= 1'b1;
          RX_MOSTLY: out_if.ready <= ($urandom_range(0, 9) < 7);
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 9) < 3);
          default:   out_if.ready <= (seg_left % 4 == 0);
        endcase
      end
    end
  end

  task automatic release_input();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  // Offer one sample beat, with bursts and gaps, and wait for acceptance
  task automatic send_sample(input logic [31:0] stamp, input logic [SAMPLE_W-1:0] sample);
    int gap;
    if (!tx_gapless) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                 : $urandom_range(1, 20);
        if (gap > 0) begin
          @(negedge clk);
          in_if.valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left--;
    end
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.time_ms      <= stamp;
    in_if.light_sample <= sample;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Everything returned, then let the pipe settle
  task automatic wait_idle();
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup, then access; shadow copy follows
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_READ_IVL:   dim_cfg.read_ivl   = val[IVL_W-1:0];
      REG_CHANGE_IVL: dim_cfg.change_ivl = val[IVL_W-1:0];
      REG_RUN_LEN:    dim_cfg.run_len    = val[RUN_W-1:0];
      REG_BRIGHT_THR: dim_cfg.bright_thr = val[SAMPLE_W-1:0];
      REG_FULL_SCALE: dim_cfg.full_scale = val[FS_W-1:0];
      REG_BRIGHT_LVL: dim_cfg.bright_lvl = val[DUTY_W-1:0];
      REG_DIM_LVL:    dim_cfg.dim_lvl    = val[DUTY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic apply_config(input int unsigned read_ms, input int unsigned change_ms,
                              input int unsigned run, input int unsigned thr,
                              input int unsigned fs_mv, input int unsigned bright,
                              input int unsigned dim);
    wait_idle();
    write_reg(REG_READ_IVL, read_ms);
    write_reg(REG_CHANGE_IVL, change_ms);
    write_reg(REG_RUN_LEN, run);
    write_reg(REG_BRIGHT_THR, thr);
    write_reg(REG_FULL_SCALE, fs_mv);
    write_reg(REG_BRIGHT_LVL, bright);
    write_reg(REG_DIM_LVL, dim);
  endtask

  // Mostly one read interval or a bit more; some early, some jumps and wraps
  task automatic advance_clock();
    int unsigned r;
    int unsigned ivl;
    r = $urandom_range(0, 99);
    ivl = 32'(dim_cfg.read_ivl);
    if (r < 2)
      clock_ms = $urandom();
    else if (r < 4)
      clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * ivl + 50);
    else if (r < 14)
      clock_ms = clock_ms + $urandom_range(0, ivl);
    else
      clock_ms = clock_ms + ivl + $urandom_range(0, ivl / 2 + 40);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input light_seq_t kind);
    int unsigned thr;
    thr = 32'(dim_cfg.bright_thr);
    if (kind == SEQ_BRIGHT && thr < ADC_FULL)
      return SAMPLE_W'(($urandom_range(0, 9) == 0) ? ADC_FULL
                                                   : $urandom_range(thr + 1, ADC_FULL));
    if (kind == SEQ_DIM)
      return SAMPLE_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, thr));
    return SAMPLE_W'($urandom_range(0, ADC_FULL));
  endfunction

  // Runs of bright or dim samples, some long enough to saturate, mixed with noise
  task automatic run_random_samples(input int count);
    int         sent;
    int         len;
    int         k;
    int unsigned r;
    light_seq_t kind;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 9);
      kind = (r < 4) ? SEQ_BRIGHT : (r < 8) ? SEQ_DIM : SEQ_NOISE;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 300)
                                         : $urandom_range(1, 2 * dim_cfg.run_len + 3);
      for (k = 0; k < len && sent < count; k++) begin
        advance_clock();
        send_sample(clock_ms, pick_sample(kind));
        sent++;
      end
    end
  endtask

  // Reset settings: skipped samples, threshold edge, rate limit from time
  // zero, both switches, timestamp wrap
  task automatic test_reset_behavior();
    send_sample(32'd0, 12'd4095);
    send_sample(32'd99, 12'd0);
    send_sample(32'd100, 12'd4095);
    send_sample(32'd200, 12'd1985);
    send_sample(32'd300, 12'd0);
    send_sample(32'd400, 12'd17);
    send_sample(32'd500, 12'd1000);
    send_sample(32'd600, 12'd0);
    send_sample(32'd999, 12'd0);
    send_sample(32'd1099, 12'd0);
    send_sample(32'd1199, 12'd1986);
    send_sample(32'd1299, 12'd4095);
    send_sample(32'd1399, 12'd3000);
    send_sample(32'd1499, 12'd2500);
    send_sample(32'd1599, 12'd4095);
    send_sample(32'd2099, 12'd4095);
    send_sample(32'hFFFF_FFFF, 12'd2048);
    send_sample(32'h0000_0062, 12'd0);
    send_sample(32'h0000_0063, 12'd4095);
    clock_ms = 32'h0000_0063;
  endtask

  task automatic test_default_random();
    run_random_samples(250);
  endtask

  // Every sample kept, every run switches at once, inverted levels
  task automatic test_every_sample_kept();
    apply_config(0, 0, 1, 0, 1000, 0, 255);
    run_random_samples(200);
  endtask

  task automatic test_slow_intervals();
    apply_config(16'hFFFF, 16'hFFFF, 2, 4095, 5000, 128, 0);
    run_random_samples(150);
  endtask

  // Equal levels leave the counters running into saturation
  task automatic test_run_saturation();
    apply_config(10, 50, 200, 2048, 4095, 200, 200);
    run_random_samples(200);
  endtask

  // Zero run length: only the bright side can switch
  task automatic test_run_length_zero();
    apply_config(20, 200, 0, 1000, 2500, 30, 220);
    run_random_samples(150);
  endtask

  // Result side held off while samples keep coming; then a full drain pause
  task automatic test_backpressure();
    int k;
    apply_config(0, 0, 1, 2048, 3300, 240, 15);
    tx_gapless = 1'b1;
    rx_hold_req = 1'b1;
    for (k = 0; k < 80; k++) begin
      advance_clock();
      send_sample(clock_ms, SAMPLE_W'($urandom_range(0, ADC_FULL)));
    end
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    for (k = 0; k < 40; k++) begin
      advance_clock();
      send_sample(clock_ms, SAMPLE_W'($urandom_range(0, ADC_FULL)));
    end
    tx_gapless = 1'b0;
  endtask

  task automatic test_random_settings();
    int k;
    for (k = 0; k < 3; k++) begin
      apply_config($urandom_range(0, 300), $urandom_range(0, 2000), $urandom_range(1, 8),
                   $urandom_range(0, ADC_FULL), $urandom_range(1000, 5000),
                   $urandom_range(0, 255), $urandom_range(0, 255));
      run_random_samples(70);
    end
  endtask

  initial begin : main_seq
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.time_ms      = '0;
    in_if.light_sample = '0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;

    // shadow state after reset
    dim_cfg.read_ivl   = READ_IVL_RST;
    dim_cfg.change_ivl = CHANGE_IVL_RST;
    dim_cfg.run_len    = RUN_LEN_RST;
    dim_cfg.bright_thr = BRIGHT_THR_RST;
    dim_cfg.full_scale = FULL_SCALE_RST;
    dim_cfg.bright_lvl = BRIGHT_LVL_RST;
    dim_cfg.dim_lvl    = DIM_LVL_RST;
    last_sample_ms     = '0;
    last_change_ms     = '0;
    bright_cnt         = '0;
    dim_cnt            = '0;
    duty_now           = DUTY_RST;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_behavior();
    test_default_random();
    test_every_sample_kept();
    test_slow_intervals();
    test_run_saturation();
    test_run_length_zero();
    test_backpressure();
    test_random_settings();
    wait_idle();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/albd_pkg.sv
sv/albd_if.sv
sv/albd_ctrl.sv
sv/albd_fmt.sv
sv/ambient_light_backlight_dimmer.sv
dv/tb_ambient_light_backlight_dimmer.sv
